[hw/rtl/drd_pkg.sv]
// Shared types and constants for the detection row decoder.
package drd_pkg;

    localparam int MAX_CLASSES = 256;
    localparam int VALUE_W     = 16;
    localparam int POS_W       = 9;
    localparam int IDX_W       = 8;
    localparam int COORD_W     = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 9;

    // Geometry and score elements at the head of each row
    localparam logic [POS_W-1:0] POS_CENTRE_X   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CENTRE_Y   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BOX_W      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_BOX_H      = POS_W'(3);
    localparam logic [POS_W-1:0] POS_OBJECTNESS = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FIRST_CLS  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_MAX_LAST   = POS_W'(4 + MAX_CLASSES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_THRESHOLD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE         = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE         = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = CFG_IDX_W'(4);

    localparam logic [VALUE_W-1:0] CONF_THRESHOLD_RST  = 16'd29491;
    localparam logic [VALUE_W-1:0] CLASS_THRESHOLD_RST = 16'd26214;
    localparam logic [VALUE_W-1:0] SCALE_RST           = 16'd4096;
    localparam logic [COUNT_W-1:0] CLASS_COUNT_RST     = 9'd80;

    typedef struct packed {
        logic [VALUE_W-1:0] conf_threshold;
        logic [VALUE_W-1:0] class_threshold;
        logic [VALUE_W-1:0] x_scale;
        logic [VALUE_W-1:0] y_scale;
        logic [COUNT_W-1:0] class_count;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] centre_x;
        logic [VALUE_W-1:0] centre_y;
        logic [VALUE_W-1:0] box_w;
        logic [VALUE_W-1:0] box_h;
        logic [VALUE_W-1:0] objectness;
        logic [IDX_W-1:0]   class_index;
    } row_t;

endpackage

[hw/rtl/drd_row_acc.sv]
// Row accumulator: tracks element position, keeps geometry and best class, closes rows.
module drd_row_acc
    import drd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               row_valid,
    input  logic               row_stall,
    output row_t               row
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] cx_reg, cx_next;
    logic [VALUE_W-1:0] cy_reg, cy_next;
    logic [VALUE_W-1:0] w_reg, w_next;
    logic [VALUE_W-1:0] h_reg, h_next;
    logic [VALUE_W-1:0] obj_reg, obj_next;
    logic [VALUE_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               row_valid_reg, row_valid_next;
    row_t               row_reg;

    logic [COUNT_W-1:0] n_eff;
    logic [POS_W-1:0]   last_pos;
    logic [POS_W-1:0]   cls_k;
    logic               accept;
    logic               close;
    logic               keep;

    assign in_stall  = row_valid_reg & row_stall;
    assign accept    = in_valid & ~in_stall;
    assign row_valid = row_valid_reg;
    assign row       = row_reg;

    // Clamp the class count to 1..MAX_CLASSES
    always_comb
    begin
        if (cfg.class_count == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (cfg.class_count > COUNT_W'(MAX_CLASSES))
        begin
            n_eff = COUNT_W'(MAX_CLASSES);
        end
        else
        begin
            n_eff = cfg.class_count;
        end
    end

    assign last_pos = POS_W'(4) + POS_W'(n_eff);
    assign close    = (pos_reg >= last_pos);
    assign cls_k    = pos_reg - POS_FIRST_CLS;

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        obj_next  = obj_reg;
        best_next = best_reg;
        idx_next  = idx_reg;
        unique case (pos_reg)
            POS_CENTRE_X:   cx_next  = value;
            POS_CENTRE_Y:   cy_next  = value;
            POS_BOX_W:      w_next   = value;
            POS_BOX_H:      h_next   = value;
            POS_OBJECTNESS: obj_next = value;
            default:
            begin
                // first score always wins, later ones only when strictly higher
                if ((cls_k == '0) || (value > best_reg))
                begin
                    best_next = value;
                    idx_next  = cls_k[IDX_W-1:0];
                end
            end
        endcase
    end

    assign pos_next = close ? '0 : pos_reg + POS_W'(1);
    assign keep     = (obj_next >= cfg.conf_threshold) && (best_next > cfg.class_threshold);

    always_comb
    begin
        if (accept && close && keep)
        begin
            row_valid_next = 1'b1;
        end
        else if (row_stall)
        begin
            row_valid_next = row_valid_reg;
        end
        else
        begin
            row_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            obj_reg       <= '0;
            best_reg      <= '0;
            idx_reg       <= '0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (accept)
            begin
                pos_reg  <= pos_next;
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                w_reg    <= w_next;
                h_reg    <= h_next;
                obj_reg  <= obj_next;
                best_reg <= best_next;
                idx_reg  <= idx_next;
            end
        end
    end

    // Capture the closed row when it is kept
    always_ff @(posedge clk)
    begin
        if (accept && close && keep)
        begin
            row_reg.centre_x    <= cx_next;
            row_reg.centre_y    <= cy_next;
            row_reg.box_w       <= w_next;
            row_reg.box_h       <= h_next;
            row_reg.objectness  <= obj_next;
            row_reg.class_index <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX_LAST)
        else $error("element position past the longest row");

    a_close_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && close |=> pos_reg == '0)
        else $error("row did not restart after its last element");

    a_kept_row_offered: assert property (@(posedge clk) disable iff (!rst_n)
        accept && close && keep |=> row_valid_reg)
        else $error("kept row not offered downstream");

    a_no_close_no_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(row_valid_reg) |-> $past(accept && close))
        else $error("row offered without a closing transaction");
`endif

endmodule

[hw/rtl/drd_box_calc.sv]
// Box arithmetic: scale products, truncation toward zero and saturation.
module drd_box_calc
    import drd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [VALUE_W-1:0]  x_scale,
    input  logic [VALUE_W-1:0]  y_scale,
    input  logic                row_valid,
    output logic                row_stall,
    input  row_t                row,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [IDX_W-1:0]    class_index,
    output logic [VALUE_W-1:0]  objectness,
    output logic signed [COORD_W-1:0] box_left,
    output logic signed [COORD_W-1:0] box_top,
    output logic [COORD_W-1:0]  box_width,
    output logic [COORD_W-1:0]  box_height
);

    localparam int DIFF_W  = VALUE_W + 2;
    localparam int SCALE_W = VALUE_W + 1;
    localparam int EPROD_W = DIFF_W + SCALE_W;
    localparam int SPROD_W = 2 * VALUE_W;
    localparam int EDGE_SH = 19;
    localparam int SIZE_SH = 18;
    localparam int EDGE_W  = EPROD_W - EDGE_SH;
    localparam int SIZE_W  = SPROD_W - SIZE_SH;

    // Saturate a truncated edge to the signed coordinate range
    function automatic logic [COORD_W-1:0] sat_edge(input logic signed [EDGE_W-1:0] e);
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] hi;
        logic [COORD_W-1:0]       r;
        lo = -(EDGE_W'(1) <<< (COORD_W - 1));
        hi = (EDGE_W'(1) <<< (COORD_W - 1)) - EDGE_W'(1);
        if (e < lo)
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else if (e > hi)
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r = e[COORD_W-1:0];
        end
        return r;
    endfunction

    // Round a signed product toward zero after the shift
    function automatic logic signed [EDGE_W-1:0] trunc_edge(input logic signed [EPROD_W-1:0] p);
        logic signed [EPROD_W-1:0] s;
        s = p + (p[EPROD_W-1] ? EPROD_W'((1 << EDGE_SH) - 1) : EPROD_W'(0));
        return s[EPROD_W-1:EDGE_SH];
    endfunction

    function automatic logic [COORD_W-1:0] sat_size(input logic [SPROD_W-1:0] p);
        logic [SIZE_W-1:0] s;
        s = p[SPROD_W-1:SIZE_SH];
        return (s > SIZE_W'({COORD_W{1'b1}})) ? {COORD_W{1'b1}} : s[COORD_W-1:0];
    endfunction

    logic                      p_valid_reg;
    logic signed [EPROD_W-1:0] prod_left_reg;
    logic signed [EPROD_W-1:0] prod_top_reg;
    logic [SPROD_W-1:0]        prod_w_reg;
    logic [SPROD_W-1:0]        prod_h_reg;
    logic [IDX_W-1:0]          p_idx_reg;
    logic [VALUE_W-1:0]        p_obj_reg;

    logic                      o_valid_reg;
    logic [IDX_W-1:0]          o_idx_reg;
    logic [VALUE_W-1:0]        o_obj_reg;
    logic [COORD_W-1:0]        o_left_reg;
    logic [COORD_W-1:0]        o_top_reg;
    logic [COORD_W-1:0]        o_w_reg;
    logic [COORD_W-1:0]        o_h_reg;

    logic                      o_free;
    logic                      p_free;
    logic signed [DIFF_W-1:0]  diff_x;
    logic signed [DIFF_W-1:0]  diff_y;
    logic signed [SCALE_W-1:0] sx;
    logic signed [SCALE_W-1:0] sy;

    assign o_free    = ~o_valid_reg | ~out_stall;
    assign p_free    = ~p_valid_reg | o_free;
    assign row_stall = ~p_free;

    // 2*centre - size, exact in units of 2^-7
    assign diff_x = $signed({1'b0, row.centre_x, 1'b0}) - $signed({2'b00, row.box_w});
    assign diff_y = $signed({1'b0, row.centre_y, 1'b0}) - $signed({2'b00, row.box_h});
    assign sx     = $signed({1'b0, x_scale});
    assign sy     = $signed({1'b0, y_scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= row_valid;
            end
            if (o_free)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && row_valid)
        begin
            prod_left_reg <= diff_x * sx;
            prod_top_reg  <= diff_y * sy;
            prod_w_reg    <= row.box_w * x_scale;
            prod_h_reg    <= row.box_h * y_scale;
            p_idx_reg     <= row.class_index;
            p_obj_reg     <= row.objectness;
        end
        if (o_free && p_valid_reg)
        begin
            o_idx_reg  <= p_idx_reg;
            o_obj_reg  <= p_obj_reg;
            o_left_reg <= sat_edge(trunc_edge(prod_left_reg));
            o_top_reg  <= sat_edge(trunc_edge(prod_top_reg));
            o_w_reg    <= sat_size(prod_w_reg);
            o_h_reg    <= sat_size(prod_h_reg);
        end
    end

    assign out_valid   = o_valid_reg;
    assign class_index = o_idx_reg;
    assign objectness  = o_obj_reg;
    assign box_left    = $signed(o_left_reg);
    assign box_top     = $signed(o_top_reg);
    assign box_width   = o_w_reg;
    assign box_height  = o_h_reg;

`ifndef SYNTHESIS
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !o_free |=> p_valid_reg && $stable(prod_left_reg) && $stable(prod_w_reg))
        else $error("product stage changed while the output was blocked");

    a_prod_drain: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && o_free |=> o_valid_reg)
        else $error("product stage result lost on its way to the output");

    a_row_taken: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall |=> p_valid_reg)
        else $error("row taken but product stage empty");
`endif

endmodule

[hw/rtl/detection_row_decoder_unit.sv]
// Top level of the detection row decoder: configuration registers and stage wiring.
// Throughput: one row element per cycle while in_stall is low, with no gaps between rows.
// A kept box is offered on out_valid once it has passed through the row register,
// the product register and the output register.
// Stalls on the output back up through the three stages into in_stall.
// Reset clears the row position, row state and pipeline; registers load their defaults.
module detection_row_decoder_unit
    import drd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_W-1:0]    value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      class_index,
    output logic [VALUE_W-1:0]    objectness,
    output logic signed [COORD_W-1:0] box_left,
    output logic signed [COORD_W-1:0] box_top,
    output logic [COORD_W-1:0]    box_width,
    output logic [COORD_W-1:0]    box_height
);

    cfg_t cfg_reg;
    logic row_valid;
    logic row_stall;
    row_t row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_threshold  <= CONF_THRESHOLD_RST;
            cfg_reg.class_threshold <= CLASS_THRESHOLD_RST;
            cfg_reg.x_scale         <= SCALE_RST;
            cfg_reg.y_scale         <= SCALE_RST;
            cfg_reg.class_count     <= CLASS_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CONF_THRESHOLD:  cfg_reg.conf_threshold  <= cfg_data;
                REG_CLASS_THRESHOLD: cfg_reg.class_threshold <= cfg_data;
                REG_X_SCALE:         cfg_reg.x_scale         <= cfg_data;
                REG_Y_SCALE:         cfg_reg.y_scale         <= cfg_data;
                REG_CLASS_COUNT:     cfg_reg.class_count     <= cfg_data[COUNT_W-1:0];
                default:             ; // unmapped index: drop
            endcase
        end
    end

    drd_row_acc u_row_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row       (row)
    );

    drd_box_calc u_box_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_scale     (cfg_reg.x_scale),
        .y_scale     (cfg_reg.y_scale),
        .row_valid   (row_valid),
        .row_stall   (row_stall),
        .row         (row),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .class_index (class_index),
        .objectness  (objectness),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height)
    );

endmodule

[tb/tb_detection_row_decoder_unit.sv]
// Self-checking testbench for the detection row decoder: directed rows, then randomized phases.
module tb_detection_row_decoder_unit;
    import drd_pkg::*;

    localparam int IDLE_PCT       = 11;
    localparam int STALL_PCT      = 11;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TAIL_CYCLES    = 10;
    localparam int ITEM_TARGET    = 550;
    localparam int DIRECTED_ROWS  = 4;

    typedef struct packed {
        logic [IDX_W-1:0]          class_index;
        logic [VALUE_W-1:0]        objectness;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic [COORD_W-1:0]        box_width;
        logic [COORD_W-1:0]        box_height;
    } box_t;

    typedef struct packed {
        logic [COUNT_W-1:0] classes;
        logic [VALUE_W-1:0] cx;
        logic [VALUE_W-1:0] cy;
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] h;
        logic [VALUE_W-1:0] obj;
        logic [VALUE_W-1:0] score0;
        logic [VALUE_W-1:0] score1;
        logic               typed;
        logic               kept;
        box_t               box;
    } row_case_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [VALUE_W-1:0]        value;
    logic                      out_valid;
    logic                      out_stall;
    logic [IDX_W-1:0]          class_index;
    logic [VALUE_W-1:0]        objectness;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [COORD_W-1:0]        box_width;
    logic [COORD_W-1:0]        box_height;

    // Decoder mirror: register copy and row state
    cfg_t               settings;
    row_t               row_state;
    logic [VALUE_W-1:0] top_score;
    logic [POS_W-1:0]   elem_pos;
    bit                 typed_row;

    box_t      boxes_due[$];
    row_case_t directed_rows [DIRECTED_ROWS];
    int        items_sent;
    int        boxes_predicted;
    int        boxes_seen;
    int        mismatches;
    int        quiet_cycles;
    bit        hold_done;
    box_t      got_box;
    box_t      want_box;

    detection_row_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .class_index (class_index),
        .objectness  (objectness),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height)
    );

    always #10 clk = ~clk;

    // (2*centre - size) is in units of 2^-7; times Q4.12 gives 2^-19
    function automatic logic signed [COORD_W-1:0] scaled_corner(
        input logic [VALUE_W-1:0] centre,
        input logic [VALUE_W-1:0] extent,
        input logic [VALUE_W-1:0] scale
    );
        longint offset;
        longint product;
        longint pixels;
        offset  = 2 * longint'(centre) - longint'(extent);
        product = offset * longint'(scale);
        pixels  = (product < 0) ? -((-product) >>> 19) : (product >>> 19);
        if (pixels < -4096)
            pixels = -4096;
        if (pixels > 4095)
            pixels = 4095;
        return pixels[COORD_W-1:0];
    endfunction

    // Q10.6 times Q4.12 is in units of 2^-18
    function automatic logic [COORD_W-1:0] scaled_size(
        input logic [VALUE_W-1:0] extent,
        input logic [VALUE_W-1:0] scale
    );
        longint pixels;
        pixels = (longint'(extent) * longint'(scale)) >> 18;
        if (pixels > 8191)
            pixels = 8191;
        return pixels[COORD_W-1:0];
    endfunction

    task automatic decode_element(input logic [VALUE_W-1:0] v);
        int   n;
        int   last;
        int   k;
        box_t b;
        n = settings.class_count;
        if (n == 0)
            n = 1;
        if (n > MAX_CLASSES)
            n = MAX_CLASSES;
        last = int'(POS_OBJECTNESS) + n;
        case (elem_pos)
            POS_CENTRE_X:   row_state.centre_x   = v;
            POS_CENTRE_Y:   row_state.centre_y   = v;
            POS_BOX_W:      row_state.box_w      = v;
            POS_BOX_H:      row_state.box_h      = v;
            POS_OBJECTNESS: row_state.objectness = v;
            default:
            begin
                k = int'(elem_pos) - int'(POS_FIRST_CLS);
                // keep the first maximum: only a strictly higher score replaces it
                if (k == 0 || v > top_score)
                begin
                    top_score             = v;
                    row_state.class_index = IDX_W'(k);
                end
            end
        endcase
        if (int'(elem_pos) < last)
            elem_pos = elem_pos + 1'b1;
        else
        begin
            elem_pos = '0;
            if (row_state.objectness >= settings.conf_threshold &&
                top_score > settings.class_threshold)
            begin
                b.class_index = row_state.class_index;
                b.objectness  = row_state.objectness;
                b.box_left    = scaled_corner(row_state.centre_x, row_state.box_w,
                                              settings.x_scale);
                b.box_top     = scaled_corner(row_state.centre_y, row_state.box_h,
                                              settings.y_scale);
                b.box_width   = scaled_size(row_state.box_w, settings.x_scale);
                b.box_height  = scaled_size(row_state.box_h, settings.y_scale);
                if (!typed_row)
                begin
                    boxes_due = {boxes_due, b};
                    boxes_predicted++;
                end
            end
        end
    endtask

    // Row-aware value source: mostly plausible rows, some noise
    function automatic logic [VALUE_W-1:0] pick_element();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return VALUE_W'($urandom);
        if (elem_pos < POS_OBJECTNESS)
        begin
            if (roll < 18)
                return '0;
            if (roll < 28)
                return '1;
            if (roll < 70)
                return VALUE_W'($urandom_range(40960, 0));
            return VALUE_W'($urandom);
        end
        if (elem_pos == POS_OBJECTNESS)
        begin
            if (roll < 75)
                return VALUE_W'($urandom_range(16'hFFFF, settings.conf_threshold));
            return VALUE_W'($urandom);
        end
        if (roll < 25)
            return top_score;
        if (roll < 33)
            return '0;
        if (roll < 41)
            return '1;
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [VALUE_W-1:0] random_threshold();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 22)
            return '1;
        return VALUE_W'($urandom_range(50000, 0));
    endfunction

    function automatic logic [VALUE_W-1:0] random_scale();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return VALUE_W'($urandom_range(20000, 1024));
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (!(items_sent >= 200 && items_sent < 320) && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        decode_element(v);
    endtask

    // Hold off until every box is out, then let rejected rows leave the pipeline
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_CONF_THRESHOLD:  settings.conf_threshold  = data;
            REG_CLASS_THRESHOLD: settings.class_threshold = data;
            REG_X_SCALE:         settings.x_scale         = data;
            REG_Y_SCALE:         settings.y_scale         = data;
            REG_CLASS_COUNT:     settings.class_count     = data[COUNT_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic program_settings(input logic [7:0] mask, input cfg_t s);
        logic [CFG_DATA_W-1:0] count_word;
        if (mask[REG_CONF_THRESHOLD])
            write_register(REG_CONF_THRESHOLD, s.conf_threshold);
        if (mask[REG_CLASS_THRESHOLD])
            write_register(REG_CLASS_THRESHOLD, s.class_threshold);
        if (mask[REG_X_SCALE])
            write_register(REG_X_SCALE, s.x_scale);
        if (mask[REG_Y_SCALE])
            write_register(REG_Y_SCALE, s.y_scale);
        if (mask[REG_CLASS_COUNT])
        begin
            // junk in the upper bits must be dropped
            count_word                = CFG_DATA_W'($urandom);
            count_word[COUNT_W-1:0]   = s.class_count;
            write_register(REG_CLASS_COUNT, count_word);
        end
        if ($urandom_range(4) == 0)
            write_register(CFG_IDX_W'(REG_CLASS_COUNT + 1 + $urandom_range(2)),
                           CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic report_box(input box_t want, input box_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("box mismatch: expected idx %0d obj %0d left %0d top %0d w %0d h %0d",
                     want.class_index, want.objectness, want.box_left, want.box_top,
                     want.box_width, want.box_height);
            $display("              got idx %0d obj %0d left %0d top %0d w %0d h %0d",
                     got.class_index, got.objectness, got.box_left, got.box_top,
                     got.box_width, got.box_height);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_box.class_index = class_index;
            got_box.objectness  = objectness;
            got_box.box_left    = box_left;
            got_box.box_top     = box_top;
            got_box.box_width   = box_width;
            got_box.box_height  = box_height;
            if (boxes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected box: idx %0d obj %0d left %0d top %0d w %0d h %0d",
                             class_index, objectness, box_left, box_top, box_width,
                             box_height);
            end
            else
            begin
                want_box = boxes_due.pop_front();
                if (got_box.class_index !== want_box.class_index ||
                    got_box.objectness  !== want_box.objectness  ||
                    got_box.box_left    !== want_box.box_left    ||
                    got_box.box_top     !== want_box.box_top     ||
                    got_box.box_width   !== want_box.box_width   ||
                    got_box.box_height  !== want_box.box_height)
                    report_box(want_box, got_box);
            end
            boxes_seen <= boxes_seen + 1;
        end
    end

    // Output back-pressure, with one long hold-off to fill the pipeline
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && boxes_seen >= 3)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                out_stall <= !(boxes_seen >= 20 && boxes_seen < 35) &&
                             ($urandom_range(99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        row_case_t    rc;
        cfg_t         s;
        logic [7:0]   mask;
        int           items;
        int           phase;
        int           roll;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        settings  = '{CONF_THRESHOLD_RST, CLASS_THRESHOLD_RST, SCALE_RST, SCALE_RST,
                      CLASS_COUNT_RST};
        row_state       = '0;
        top_score       = '0;
        elem_pos        = '0;
        typed_row       = 1'b0;
        items_sent      = 0;
        boxes_predicted = 0;
        boxes_seen      = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        hold_done       = 1'b0;

        // Fields: classes, cx, cy, w, h, obj, score0, score1, typed, kept, box
        // All-zero geometry at unit scale, full confidence
        directed_rows[0] = '{9'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                             1'b1, 1'b1, '{8'd0, 16'hFFFF, 13'sd0, 13'sd0, 13'd0, 13'd0}};
        // Full-scale geometry, objectness one below its threshold
        directed_rows[1] = '{9'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd29490,
                             16'hFFFF, 16'd0, 1'b1, 1'b0, '0};
        // Objectness exactly at threshold kept; tied scores give the first index
        directed_rows[2] = '{9'd2, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd29491, 16'd26215,
                             16'd26215, 1'b1, 1'b1,
                             '{8'd0, 16'd29491, 13'sd1023, -13'sd511, 13'd0, 13'd1023}};
        // Zero class count acts as one; best score equal to its threshold is dropped
        directed_rows[3] = '{9'd0, 16'd12800, 16'd12800, 16'd6400, 16'd6400, 16'hFFFF,
                             16'd26214, 16'd0, 1'b1, 1'b0, '0};

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            rc = directed_rows[r];
            if (rc.classes != settings.class_count)
            begin
                settle_pipeline();
                mask                  = '0;
                mask[REG_CLASS_COUNT] = 1'b1;
                s                     = settings;
                s.class_count         = rc.classes;
                program_settings(mask, s);
            end
            typed_row = 1'b1;
            send_value(rc.cx);
            send_value(rc.cy);
            send_value(rc.w);
            send_value(rc.h);
            send_value(rc.obj);
            send_value(rc.score0);
            if (rc.classes == 2)
                send_value(rc.score1);
            typed_row = 1'b0;
            if (rc.kept)
            begin
                boxes_due = {boxes_due, rc.box};
                boxes_predicted++;
            end
        end

        // Phases end at arbitrary points, so counts also change in mid-row
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase++;
            settle_pipeline();
            mask = '0;
            s    = settings;
            case (phase)
                1:
                begin
                    mask[REG_CONF_THRESHOLD]  = 1'b1;
                    mask[REG_CLASS_THRESHOLD] = 1'b1;
                    mask[REG_CLASS_COUNT]     = 1'b1;
                    s.conf_threshold          = '0;
                    s.class_threshold         = '0;
                    s.class_count             = 9'd1;
                    items                     = 120;
                end
                2:
                begin
                    mask[REG_X_SCALE]     = 1'b1;
                    mask[REG_Y_SCALE]     = 1'b1;
                    mask[REG_CLASS_COUNT] = 1'b1;
                    s.x_scale             = '1;
                    s.y_scale             = '0;
                    s.class_count         = 9'd511;
                    items                 = 270;
                end
                3:
                begin
                    mask                      = 8'h1F;
                    s.conf_threshold          = '1;
                    s.class_threshold         = '1;
                    s.x_scale                 = SCALE_RST;
                    s.y_scale                 = SCALE_RST;
                    s.class_count             = 9'd1;
                    items                     = 30;
                end
                4:
                begin
                    mask                      = 8'h1F;
                    s.conf_threshold          = CONF_THRESHOLD_RST;
                    s.class_threshold         = CLASS_THRESHOLD_RST;
                    s.x_scale                 = '1;
                    s.y_scale                 = '1;
                    s.class_count             = 9'd2;
                    items                     = 40;
                end
                default:
                begin
                    if ($urandom_range(1))
                    begin
                        mask[REG_CONF_THRESHOLD] = 1'b1;
                        s.conf_threshold         = random_threshold();
                    end
                    if ($urandom_range(1))
                    begin
                        mask[REG_CLASS_THRESHOLD] = 1'b1;
                        s.class_threshold         = random_threshold();
                    end
                    if ($urandom_range(1))
                    begin
                        mask[REG_X_SCALE] = 1'b1;
                        s.x_scale         = random_scale();
                    end
                    if ($urandom_range(1))
                    begin
                        mask[REG_Y_SCALE] = 1'b1;
                        s.y_scale         = random_scale();
                    end
                    if ($urandom_range(1))
                    begin
                        mask[REG_CLASS_COUNT] = 1'b1;
                        roll = $urandom_range(99);
                        if (roll < 10)
                            s.class_count = '0;
                        else if (roll < 75)
                            s.class_count = COUNT_W'($urandom_range(6, 1));
                        else if (roll < 88)
                            s.class_count = COUNT_W'($urandom_range(24, 7));
                        else if (roll < 94)
                            s.class_count = 9'd80;
                        else
                            s.class_count = 9'd256;
                    end
                    items = $urandom_range(80, 15);
                end
            endcase
            program_settings(mask, s);
            repeat (items)
                send_value(pick_element());
        end

        in_valid <= 1'b0;
        while (boxes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && boxes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
